// ----- src/tcp_retransmit_segment_queue_macros.svh -----
// assertion macros used by the checker file
`ifndef TCP_RETRANSMIT_SEGMENT_QUEUE_MACROS_SVH
`define TCP_RETRANSMIT_SEGMENT_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define TRSQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trsq assertion failed");

// next-cycle implication, sampled on clk, quiet during reset
`define TRSQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trsq assertion failed");

`endif

// ----- src/trsq_pkg.sv -----
package trsq_pkg;

  localparam int DefSlotCount = 16;
  localparam int DefMaxSegmentBytes = 512;

  // command codes
  localparam logic [2:0] CMD_PUSH   = 3'd0;
  localparam logic [2:0] CMD_SEND   = 3'd1;
  localparam logic [2:0] CMD_ACK    = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_FLUSH  = 3'd4;
  localparam logic [2:0] CMD_STATUS = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NO_PENDING = 3'd1;
  localparam logic [2:0] ST_NO_RANK    = 3'd2;
  localparam logic [2:0] ST_FULL       = 3'd3;
  localparam logic [2:0] ST_TOO_LONG   = 3'd4;

  // mask keeping the low b bytes of a word
  function automatic logic [63:0] byte_mask(input logic [3:0] b);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < b) m[8*i +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

// ----- src/trsq_ram.sv -----
module trsq_ram #(
  parameter int Width = 64,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ----- src/tcp_retransmit_segment_queue.sv -----
// channel | handshake            | word
// input   | in_valid / in_stall  | cmd, data_word, word_bytes, last_word, seq_value, rank
// output  | out_valid / out_stall| status, out_word, out_bytes, last, seg_length, seg_tag,
//         |                      | pending_count, backup_count, removed_count
// push, flush, status and rejected commands: result in the output register
// send and read: slot length and tag are read first, then each payload word is fetched
//   from the payload memory read port and waits while the output is stalled
// acknowledge: a walk over the tag memory, one read and one compare per freed segment
// reset clears state, pointers, counts and flags only; the memories need no clearing
// a stalled output holds the word and the next item is not taken until it moves
module tcp_retransmit_segment_queue
  import trsq_pkg::*;
#(
  parameter int SLOT_COUNT = DefSlotCount,
  parameter int MAX_SEGMENT_BYTES = DefMaxSegmentBytes
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [63:0] data_word,
  input  logic [3:0]  word_bytes,
  input  logic        last_word,
  input  logic [31:0] seq_value,
  input  logic [3:0]  rank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [63:0] out_word,
  output logic [3:0]  out_bytes,
  output logic        last,
  output logic [9:0]  seg_length,
  output logic [31:0] seg_tag,
  output logic [4:0]  pending_count,
  output logic [4:0]  backup_count,
  output logic [4:0]  removed_count
);

  localparam int Wps   = (MAX_SEGMENT_BYTES + 7) / 8;
  localparam int Sw    = $clog2(SLOT_COUNT);
  localparam int Cw    = $clog2(SLOT_COUNT + 1);
  localparam int Lw    = $clog2(MAX_SEGMENT_BYTES + 1);
  localparam int Aw    = $clog2(SLOT_COUNT * Wps);
  localparam int Fw    = $clog2(Wps) + 1;
  localparam int Kw    = $clog2(Wps + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_META, S_WREQ, S_WOUT, S_ACK_RD, S_ACK_CMP
  } state_t;

  state_t          state;
  logic [Sw-1:0]   oldest, first_pend, next_free, cur_slot;
  logic [Cw-1:0]   pend_tot, back_tot, removed;
  logic [Fw-1:0]   fill;
  logic            dropping;
  logic [31:0]     seq_q, cur_tag;
  logic            tag_mem;
  logic [Lw-1:0]   cur_len;
  logic [Kw-1:0]   k, n_words;

  logic            acc;
  logic            out_load;
  logic [3:0]      wb, b;
  logic [Sw:0]     rank_sum;
  logic [Sw-1:0]   rank_slot;
  logic [Lw+1:0]   new_len;

  logic            pay_we, pay_re, len_we, len_re, tag_we, tag_re;
  logic [Aw-1:0]   pay_wa, pay_ra;
  logic [Sw-1:0]   len_ra, tag_ra;
  logic [63:0]     pay_rd;
  logic [Lw-1:0]   len_rd;
  logic [31:0]     tag_rd;
  logic [Lw-1:0]   rem;
  logic [8:0]      pend_x, back_x, rem_x;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign acc      = in_valid && !in_stall;

  // push byte count and read-by-rank slot
  always_comb begin
    wb = (word_bytes > 4'd8) ? 4'd8 : word_bytes;
    b  = last_word ? wb : 4'd8;
    new_len = (Lw+2)'(fill) * (Lw+2)'(8) + (Lw+2)'(b);
    rank_sum = (Sw+1)'(oldest) + (Sw+1)'(rank);
    if (rank_sum >= (Sw+1)'(SLOT_COUNT)) rank_sum = rank_sum - (Sw+1)'(SLOT_COUNT);
    rank_slot = rank_sum[Sw-1:0];
  end

  // memory port control
  always_comb begin
    pay_we = acc && cmd == CMD_PUSH && !dropping
             && !(fill == '0 && (pend_tot + back_tot) >= Cw'(SLOT_COUNT))
             && !(fill >= Fw'(Wps) || new_len > (Lw+2)'(MAX_SEGMENT_BYTES));
    pay_wa = Aw'(int'(next_free) * Wps + int'(fill));
    len_we = pay_we && last_word;
    tag_we = acc && cmd == CMD_SEND && pend_tot != '0;
    len_re = acc && ((cmd == CMD_SEND && pend_tot != '0)
             || (cmd == CMD_READ && Cw'(rank) < back_tot));
    len_ra = (cmd == CMD_SEND) ? first_pend : rank_slot;
    tag_re = len_re || state == S_ACK_RD;
    tag_ra = (state == S_ACK_RD) ? oldest : len_ra;
    pay_re = state == S_WREQ;
    pay_ra = Aw'(int'(cur_slot) * Wps + int'(k));
  end

  // output register loads a new word this cycle
  always_comb begin
    out_load = 1'b0;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (cmd)
            CMD_PUSH, CMD_FLUSH, CMD_STATUS: out_load = 1'b1;
            CMD_SEND: out_load = (pend_tot == '0);
            CMD_READ: out_load = (Cw'(rank) >= back_tot);
            default: out_load = 1'b0;
          endcase
        end
      end
      S_WOUT:    out_load = !out_valid || !out_stall;
      S_ACK_RD:  out_load = (back_tot == '0);
      S_ACK_CMP: out_load = !(tag_rd < seq_q);
      default:   out_load = 1'b0;
    endcase
  end

  trsq_ram #(.Width(64), .Depth(SLOT_COUNT * Wps)) u_pay (
    .clk, .wr_en(pay_we), .wr_addr(pay_wa), .wr_data(data_word & byte_mask(b)),
    .rd_en(pay_re), .rd_addr(pay_ra), .rd_data(pay_rd)
  );

  trsq_ram #(.Width(Lw), .Depth(SLOT_COUNT)) u_len (
    .clk, .wr_en(len_we), .wr_addr(next_free), .wr_data(new_len[Lw-1:0]),
    .rd_en(len_re), .rd_addr(len_ra), .rd_data(len_rd)
  );

  trsq_ram #(.Width(32), .Depth(SLOT_COUNT)) u_tag (
    .clk, .wr_en(tag_we), .wr_addr(first_pend), .wr_data(seq_value),
    .rd_en(tag_re), .rd_addr(tag_ra), .rd_data(tag_rd)
  );

  assign rem = cur_len - Lw'(int'(k) * 8);

  // count ports take the low five bits of the counters
  assign pend_x = 9'(pend_tot);
  assign back_x = 9'(back_tot);
  assign rem_x  = 9'(removed);
  assign pending_count = pend_x[4:0];
  assign backup_count  = back_x[4:0];

  // control, pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      oldest <= '0;
      first_pend <= '0;
      next_free <= '0;
      pend_tot <= '0;
      back_tot <= '0;
      fill <= '0;
      dropping <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            seq_q <= seq_value;
            removed <= '0;
            status <= ST_OK;
            out_word <= '0;
            out_bytes <= '0;
            last <= 1'b1;
            seg_length <= '0;
            seg_tag <= '0;
            removed_count <= '0;
            case (cmd)
              CMD_PUSH: begin
                if (dropping) begin
                  if (last_word) dropping <= 1'b0;
                end else if (fill == '0 && (pend_tot + back_tot) >= Cw'(SLOT_COUNT)) begin
                  status <= ST_FULL;
                  dropping <= !last_word;
                end else if (!pay_we) begin
                  status <= ST_TOO_LONG;
                  fill <= '0;
                  dropping <= !last_word;
                end else if (last_word) begin
                  next_free <= (next_free == Sw'(SLOT_COUNT - 1)) ? '0 : next_free + 1'b1;
                  pend_tot <= pend_tot + 1'b1;
                  fill <= '0;
                end else begin
                  fill <= fill + 1'b1;
                end
              end
              CMD_SEND: begin
                if (pend_tot == '0) begin
                  status <= ST_NO_PENDING;
                end else begin
                  cur_slot <= first_pend;
                  tag_mem <= 1'b0;
                  first_pend <= (first_pend == Sw'(SLOT_COUNT - 1)) ? '0 : first_pend + 1'b1;
                  pend_tot <= pend_tot - 1'b1;
                  back_tot <= back_tot + 1'b1;
                  state <= S_META;
                end
              end
              CMD_ACK: state <= S_ACK_RD;
              CMD_READ: begin
                if (Cw'(rank) >= back_tot) begin
                  status <= ST_NO_RANK;
                end else begin
                  cur_slot <= rank_slot;
                  tag_mem <= 1'b1;
                  state <= S_META;
                end
              end
              CMD_FLUSH: begin
                removed_count <= 5'(pend_tot + back_tot);
                oldest <= '0;
                first_pend <= '0;
                next_free <= '0;
                pend_tot <= '0;
                back_tot <= '0;
                fill <= '0;
                dropping <= 1'b0;
              end
              CMD_STATUS: ;
              default: ;
            endcase
          end
        end
        // slot length and tag arrive
        S_META: begin
          cur_len <= len_rd;
          cur_tag <= tag_mem ? tag_rd : seq_q;
          n_words <= (len_rd == '0) ? Kw'(1) : Kw'((int'(len_rd) + 7) / 8);
          k <= '0;
          state <= S_WREQ;
        end
        S_WREQ: state <= S_WOUT;
        // payload word out when the register is free
        S_WOUT: begin
          if (!out_valid || !out_stall) begin
            status <= ST_OK;
            out_word <= pay_rd;
            out_bytes <= (rem >= Lw'(8)) ? 4'd8 : 4'(rem);
            last <= (k + 1'b1) == n_words;
            seg_length <= 10'(cur_len);
            seg_tag <= cur_tag;
            removed_count <= '0;
            if ((k + 1'b1) == n_words) begin
              state <= S_IDLE;
            end else begin
              k <= k + 1'b1;
              state <= S_WREQ;
            end
          end
        end
        // acknowledge walk over the oldest retransmit tags
        S_ACK_RD: begin
          if (back_tot == '0) begin
            removed_count <= rem_x[4:0];
            state <= S_IDLE;
          end else begin
            state <= S_ACK_CMP;
          end
        end
        S_ACK_CMP: begin
          if (tag_rd < seq_q) begin
            oldest <= (oldest == Sw'(SLOT_COUNT - 1)) ? '0 : oldest + 1'b1;
            back_tot <= back_tot - 1'b1;
            removed <= removed + 1'b1;
            state <= S_ACK_RD;
          end else begin
            removed_count <= rem_x[4:0];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/trsq_checker.sv -----
`include "tcp_retransmit_segment_queue_macros.svh"

module trsq_checker
  import trsq_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [2:0] cmd,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [3:0] out_bytes,
  input logic       last
);

  // a stalled word stays offered
  `TRSQ_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid)
  // status gives its word in the next cycle
  `TRSQ_ASSERT_NXT(a_status, in_valid && !in_stall && cmd == CMD_STATUS,
                   out_valid && last && status == ST_OK)
  // no new command while a segment is still streaming
  `TRSQ_ASSERT_IMP(a_busy, out_valid && !last, in_stall)
  // payload bytes only come with an ok status
  `TRSQ_ASSERT_IMP(a_bytes, out_valid && out_bytes != 4'd0, status == ST_OK)

endmodule

bind tcp_retransmit_segment_queue trsq_checker u_trsq_checker (.*);

// ----- sim/tcp_retransmit_segment_queue_tb.sv -----
`default_nettype none

module tcp_retransmit_segment_queue_tb;
  import trsq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int SLOT_WORDS = 64;
  localparam int SEG_MAX = 512;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [63:0] data_word;
    logic [3:0]  word_bytes;
    logic        last_word;
    logic [31:0] seq_value;
    logic [3:0]  rank;
  } cmd_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_word;
    logic [3:0]  out_bytes;
    logic        last;
    logic [9:0]  seg_length;
    logic [31:0] seg_tag;
    logic [4:0]  pending_count;
    logic [4:0]  backup_count;
    logic [4:0]  removed_count;
  } reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] cmd = '0;
  logic [63:0] data_word = '0;
  logic [3:0] word_bytes = '0;
  logic last_word = 1'b0;
  logic [31:0] seq_value = '0;
  logic [3:0] rank = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [63:0] out_word;
  logic [3:0] out_bytes;
  logic last;
  logic [9:0] seg_length;
  logic [31:0] seg_tag;
  logic [4:0] pending_count;
  logic [4:0] backup_count;
  logic [4:0] removed_count;

  tcp_retransmit_segment_queue dut (.*);

  always #4 clk = ~clk;

  cmd_word_t cmd_queue[$];
  reply_t reply_queue[$];
  cmd_word_t cur_word;
  int accepted = 0;
  int err_count = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  longint cycles = 0;
  logic [31:0] next_tag = 32'd100;

  // shadow of the segment ring
  logic [63:0] shadow_payload [SLOTS][SLOT_WORDS];
  logic [9:0]  shadow_len [SLOTS];
  logic [31:0] shadow_tag [SLOTS];
  logic [3:0]  head_slot = '0;
  logic [3:0]  send_slot = '0;
  logic [3:0]  fill_slot = '0;
  logic [4:0]  n_pending = '0;
  logic [4:0]  n_backup = '0;
  logic [6:0]  fill_pos = '0;
  logic        discarding = 1'b0;

  // quiet stretches on both sides
  function automatic bit calm_phase();
    return ((accepted / 40) % 3) == 0;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm_phase() || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void expect_reply(logic [2:0] st, logic [63:0] w, logic [3:0] b,
                                       logic l, logic [9:0] len, logic [31:0] tag,
                                       logic [4:0] freed);
    reply_t r;
    r = '{st, w, b, l, len, tag, n_pending, n_backup, freed};
    reply_queue.push_back(r);
  endfunction

  function automatic void expect_stream(logic [3:0] s);
    int len, n, rem;
    len = shadow_len[s];
    n = (len + 7) / 8;
    if (n == 0) n = 1;
    for (int k = 0; k < n; k++) begin
      rem = len - 8 * k;
      expect_reply(ST_OK, shadow_payload[s][k], 4'(rem >= 8 ? 8 : rem), k + 1 == n,
                   10'(len), shadow_tag[s], '0);
    end
  endfunction

  // predicted replies for one accepted command word
  function automatic void predict_replies(cmd_word_t w);
    int wb, b;
    logic [4:0] freed;
    logic [63:0] mask;
    freed = '0;
    case (w.cmd)
      CMD_PUSH: begin
        wb = (w.word_bytes > 8) ? 8 : w.word_bytes;
        if (discarding) begin
          if (w.last_word) discarding = 1'b0;
          expect_reply(ST_OK, '0, '0, 1'b1, '0, '0, '0);
        end else if (fill_pos == 0 && n_pending + n_backup >= SLOTS) begin
          discarding = !w.last_word;
          expect_reply(ST_FULL, '0, '0, 1'b1, '0, '0, '0);
        end else begin
          b = w.last_word ? wb : 8;
          if (fill_pos >= SLOT_WORDS || int'(fill_pos) * 8 + b > SEG_MAX) begin
            fill_pos = '0;
            discarding = !w.last_word;
            expect_reply(ST_TOO_LONG, '0, '0, 1'b1, '0, '0, '0);
          end else begin
            mask = (b >= 8) ? '1 : ((64'd1 << (8 * b)) - 64'd1);
            shadow_payload[fill_slot][fill_pos] = w.data_word & mask;
            if (w.last_word) begin
              shadow_len[fill_slot] = 10'(int'(fill_pos) * 8 + b);
              fill_slot++;
              n_pending++;
              fill_pos = '0;
            end else begin
              fill_pos++;
            end
            expect_reply(ST_OK, '0, '0, 1'b1, '0, '0, '0);
          end
        end
      end
      CMD_SEND: begin
        if (n_pending == 0) begin
          expect_reply(ST_NO_PENDING, '0, '0, 1'b1, '0, '0, '0);
        end else begin
          shadow_tag[send_slot] = w.seq_value;
          send_slot++;
          n_pending--;
          n_backup++;
          expect_stream(send_slot - 4'd1);
        end
      end
      CMD_ACK: begin
        while (n_backup > 0 && shadow_tag[head_slot] < w.seq_value) begin
          head_slot++;
          n_backup--;
          freed++;
        end
        expect_reply(ST_OK, '0, '0, 1'b1, '0, '0, freed);
      end
      CMD_READ: begin
        if (w.rank >= n_backup) expect_reply(ST_NO_RANK, '0, '0, 1'b1, '0, '0, '0);
        else expect_stream(head_slot + w.rank);
      end
      CMD_FLUSH: begin
        freed = n_pending + n_backup;
        head_slot = '0;
        send_slot = '0;
        fill_slot = '0;
        n_pending = '0;
        n_backup = '0;
        fill_pos = '0;
        discarding = 1'b0;
        expect_reply(ST_OK, '0, '0, 1'b1, '0, '0, freed);
      end
      CMD_STATUS: expect_reply(ST_OK, '0, '0, 1'b1, '0, '0, '0);
      default: ;
    endcase
  endfunction

  // stimulus builders
  function automatic cmd_word_t make_cmd(logic [2:0] c, logic [31:0] seq, logic [3:0] r);
    cmd_word_t w;
    w = '{c, {$urandom, $urandom}, 4'($urandom_range(0, 15)), 1'($urandom), seq, r};
    return w;
  endfunction

  function automatic void add_segment(int nbytes);
    cmd_word_t w;
    int n;
    n = (nbytes + 7) / 8;
    if (n == 0) n = 1;
    for (int k = 0; k < n; k++) begin
      w = make_cmd(CMD_PUSH, $urandom, 4'($urandom));
      w.last_word = (k + 1 == n);
      if (w.last_word) begin
        w.word_bytes = 4'(nbytes - 8 * k);
        if (nbytes - 8 * k == 8 && $urandom_range(0, 3) == 0)
          w.word_bytes = 4'($urandom_range(9, 15));
      end else if ($urandom_range(0, 4) != 0) begin
        w.word_bytes = 4'd8;
      end
      cmd_queue.push_back(w);
    end
  endfunction

  function automatic int seg_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 40);
    if (r < 95) return $urandom_range(41, 200);
    return $urandom_range(480, 530);
  endfunction

  // driver: next word offered once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        predict_replies(cur_word);
        accepted++;
        gap_left = idle_len();
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (cmd_queue.size() > 0) begin
        cur_word = cmd_queue.pop_front();
        cmd <= cur_word.cmd;
        data_word <= cur_word.data_word;
        word_bytes <= cur_word.word_bytes;
        last_word <= cur_word.last_word;
        seq_value <= cur_word.seq_value;
        rank <= cur_word.rank;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with one long hold-off to fill the block
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (!hold_done && accepted >= 120) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm_phase() && ($urandom_range(0, 99) < 30);
    end
  end

  // monitor: compare each reply word with the oldest prediction
  always @(posedge clk) begin
    reply_t e;
    if (!rst && out_valid && !out_stall) begin
      if (reply_queue.size() == 0) begin
        $error("reply word with nothing predicted");
        err_count++;
      end else begin
        e = reply_queue.pop_front();
        if (status !== e.status) begin
          $error("status expected %0d got %0d", e.status, status); err_count++;
        end
        if (out_word !== e.out_word) begin
          $error("out_word expected %h got %h", e.out_word, out_word); err_count++;
        end
        if (out_bytes !== e.out_bytes) begin
          $error("out_bytes expected %0d got %0d", e.out_bytes, out_bytes); err_count++;
        end
        if (last !== e.last) begin
          $error("last expected %0d got %0d", e.last, last); err_count++;
        end
        if (seg_length !== e.seg_length) begin
          $error("seg_length expected %0d got %0d", e.seg_length, seg_length); err_count++;
        end
        if (seg_tag !== e.seg_tag) begin
          $error("seg_tag expected %h got %h", e.seg_tag, seg_tag); err_count++;
        end
        if (pending_count !== e.pending_count) begin
          $error("pending_count expected %0d got %0d", e.pending_count, pending_count);
          err_count++;
        end
        if (backup_count !== e.backup_count) begin
          $error("backup_count expected %0d got %0d", e.backup_count, backup_count);
          err_count++;
        end
        if (removed_count !== e.removed_count) begin
          $error("removed_count expected %0d got %0d", e.removed_count, removed_count);
          err_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tcp_retransmit_segment_queue_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store cases, extremes and the full store
    cmd_queue.push_back(make_cmd(CMD_STATUS, '0, '0));
    cmd_queue.push_back(make_cmd(CMD_SEND, '0, '0));
    cmd_queue.push_back(make_cmd(CMD_READ, '0, 4'd0));
    cmd_queue.push_back(make_cmd(CMD_ACK, '1, '0));
    cmd_queue.push_back(make_cmd(CMD_SPARE_A, '1, '1));
    cmd_queue.push_back(make_cmd(CMD_SPARE_B, '0, '0));
    add_segment(0);
    add_segment(1);
    add_segment(512);
    add_segment(513);
    add_segment(600);
    cmd_queue.push_back(make_cmd(CMD_SEND, 32'd0, '0));
    cmd_queue.push_back(make_cmd(CMD_SEND, 32'hffff_ffff, '0));
    cmd_queue.push_back(make_cmd(CMD_SEND, 32'd7, '0));
    cmd_queue.push_back(make_cmd(CMD_READ, '0, 4'd1));
    cmd_queue.push_back(make_cmd(CMD_READ, '0, 4'd2));
    cmd_queue.push_back(make_cmd(CMD_READ, '0, 4'd15));
    cmd_queue.push_back(make_cmd(CMD_ACK, 32'd1, '0));
    cmd_queue.push_back(make_cmd(CMD_ACK, 32'hffff_ffff, '0));
    for (int i = 0; i < 17; i++) add_segment(i == 16 ? 20 : $urandom_range(0, 8));
    cmd_queue.push_back(make_cmd(CMD_READ, '0, 4'd0));
    cmd_queue.push_back(make_cmd(CMD_FLUSH, '0, '0));

    // random: mostly well-formed segments and sends with rising tags
    while (cmd_queue.size() < 330) begin
      r = $urandom_range(0, 99);
      if (r < 40) add_segment(seg_size());
      else if (r < 60) begin
        next_tag = next_tag + $urandom_range(0, 5);
        cmd_queue.push_back(make_cmd(CMD_SEND, next_tag, '0));
      end else if (r < 70)
        cmd_queue.push_back(make_cmd(CMD_ACK, ($urandom_range(0, 9) == 0) ? $urandom
                                     : next_tag - $urandom_range(0, 12), '0));
      else if (r < 83)
        cmd_queue.push_back(make_cmd(CMD_READ, '0, 4'($urandom_range(0, 15))));
      else if (r < 86) cmd_queue.push_back(make_cmd(CMD_FLUSH, '0, '0));
      else if (r < 91) cmd_queue.push_back(make_cmd(CMD_STATUS, '0, '0));
      else cmd_queue.push_back(make_cmd(3'($urandom_range(0, 7)), $urandom, 4'($urandom)));
    end

    while (cmd_queue.size() != 0 || in_valid || reply_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_count == 0 && reply_queue.size() == 0) begin
      $display("tcp_retransmit_segment_queue_tb: done, clean");
    end else begin
      $display("tcp_retransmit_segment_queue_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
